// ----- hdl/ncw_pkg.sv -----
// ----------------------------------------------------------------------------
// ncw_pkg
// Shared types and constants for the NewReno congestion window block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncw_pkg;

    // fraction bits of the window
    localparam int FRAC_BITS = 16;

    localparam int WIN_W  = 32;
    localparam int THR_W  = 16;
    localparam int DUP_W  = 8;
    localparam int DTH_W  = 4;
    localparam int SEQ_W  = 32;

    localparam logic [WIN_W-1:0] ONE_MSS   = WIN_W'(64'd1 << FRAC_BITS);
    localparam logic [WIN_W-1:0] WIN_MAX   = '1;
    localparam logic [WIN_W-1:0] WIN_RESET = ONE_MSS;
    localparam logic [THR_W-1:0] THR_MAX   = '1;
    localparam logic [THR_W-1:0] THR_MIN   = THR_W'(1);
    localparam logic [DUP_W-1:0] DUP_MAX   = '1;
    localparam logic [DTH_W-1:0] DTH_RESET = DTH_W'(3);
    localparam int               FR_EXTRA  = 3;

    // dividend is 2^(2*FRAC_BITS), so one quotient bit per dividend bit
    localparam int Q_W   = 2 * FRAC_BITS + 1;
    localparam int CNT_W = $clog2(Q_W);

    // widths of intermediate sums
    localparam int SUM_W = (Q_W + 1 > WIN_W + 1) ? Q_W + 1 : WIN_W + 1;
    localparam int LIM_W = (THR_W + FRAC_BITS > WIN_W) ? THR_W + FRAC_BITS : WIN_W;
    localparam int FRW_W = (THR_W + 1 + FRAC_BITS > WIN_W + 1) ?
                           THR_W + 1 + FRAC_BITS : WIN_W + 1;

    typedef enum logic [1:0] {
        PH_OPEN     = 2'd0,
        PH_DISORDER = 2'd1,
        PH_RECOVERY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_DIV  = 2'd1,
        SQ_DONE = 2'd2
    } t_seq;

    typedef struct packed {
        logic             start;
        logic [WIN_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

// ----- hdl/ncw_div.sv -----
// ----------------------------------------------------------------------------
// ncw_div
// Restoring divider for the avoidance step: 2^(2*FRAC_BITS) / divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ncw_div
    import ncw_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_div_ctl       i_ctl,
    output t_div_sts            o_sts,
    output logic [Q_W-1:0]      o_quotient
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIN_W-1:0] r_div, n_div;
    logic [WIN_W-1:0] r_rem, n_rem;
    logic [Q_W-1:0]   r_quo, n_quo;

    logic [WIN_W:0]   shifted;
    logic             ge;
    logic [WIN_W:0]   diff;

    always_comb begin
        // dividend is a single one at its top bit, zeros below
        shifted = {r_rem, (r_cnt == '0)};
        diff    = shifted - {1'b0, r_div};
        ge      = (shifted >= {1'b0, r_div});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_rem  = r_rem;
        n_quo  = r_quo;

        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_div  = i_ctl.divisor;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
            n_quo = {r_quo[Q_W-2:0], ge};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(Q_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- hdl/newreno_congestion_window.sv -----
// ----------------------------------------------------------------------------
// newreno_congestion_window
// NewReno congestion control: window, slow start threshold, duplicate count
// and recovery point, updated once per received ACK beat.
// ----------------------------------------------------------------------------
// One ACK beat is taken when the block is idle and one result beat follows.
// A slow-start, duplicate or recovery ACK moves from acceptance straight to
// the final step, which loads the output register; ready rises again in
// the same cycle as the result is offered, so no ACK is taken before the
// last one's result is offered. A congestion-avoidance ACK runs the restoring
// divider for 1/cwnd, one quotient bit per cycle over 2*FRAC_BITS+1 bits,
// before the final step. A result beat
// still waiting in the output register holds the next ACK in its final step
// until taken. dup_threshold is written through i_cfg_we / i_cfg_data; the
// user must write it only while idle, the block itself does not enforce this.
`default_nettype none

module newreno_congestion_window
    import ncw_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [3:0]   i_cfg_data,      // dup_threshold
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [63:0]  i_s_axis_tdata,  // ack_number[31:0], send_next[63:32]
    input  wire logic         i_s_axis_tuser,  // ack_is_new[0]
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // window_fixed[31:0], threshold[47:32], phase[49:48], dup_count[57:50], zero
    output logic [63:0]       o_m_axis_tdata,
    output logic [1:0]        o_m_axis_tuser   // retransmit[0], wake_sender[1]
);

    t_seq             r_seq, n_seq;
    t_phase           r_phase, n_phase;
    logic [WIN_W-1:0] r_window, n_window;
    logic [THR_W-1:0] r_thresh, n_thresh;
    logic [DUP_W-1:0] r_dup, n_dup;
    logic [SEQ_W-1:0] r_mark, n_mark;
    logic [DTH_W-1:0] r_dup_th;
    logic             r_rtx, n_rtx;
    logic             r_wake, n_wake;

    logic             r_out_valid, n_out_valid;
    logic [63:0]      r_out_data, n_out_data;
    logic [1:0]       r_out_user, n_out_user;

    t_div_ctl         div_ctl;
    t_div_sts         div_sts;
    logic [Q_W-1:0]   quotient;

    logic             s_accept;
    logic [SEQ_W-1:0] ack_number;
    logic [SEQ_W-1:0] send_next;
    logic             ack_is_new;

    logic [WIN_W:0]   win_plus_mss;
    logic [WIN_W-1:0] win_ss;
    logic [SUM_W-1:0] win_ca_sum;
    logic [WIN_W-1:0] win_ca;
    logic             in_slow_start;
    logic [WIN_W-1:0] half_raw;
    logic [THR_W-1:0] half;
    logic [FRW_W-1:0] fr_win_sum;
    logic [WIN_W-1:0] fr_win;
    logic [DUP_W-1:0] dup_bumped;
    logic [SEQ_W-1:0] ack_gap;

    ncw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .o_sts      (div_sts),
        .o_quotient (quotient)
    );

    assign ack_number = i_s_axis_tdata[31:0];
    assign send_next  = i_s_axis_tdata[63:32];
    assign ack_is_new = i_s_axis_tuser;

    assign o_s_axis_tready = (r_seq == SQ_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        win_plus_mss = {1'b0, r_window} + {1'b0, ONE_MSS};
        win_ss       = win_plus_mss[WIN_W] ? WIN_MAX : win_plus_mss[WIN_W-1:0];

        win_ca_sum = SUM_W'(r_window) + SUM_W'(quotient);
        win_ca     = (win_ca_sum > SUM_W'(WIN_MAX)) ? WIN_MAX : win_ca_sum[WIN_W-1:0];

        // a zero window takes the one-MSS step as well
        in_slow_start = (LIM_W'(r_window) < (LIM_W'(r_thresh) << FRAC_BITS))
                     || (r_window == '0);

        half_raw = r_window >> (FRAC_BITS + 1);
        if (half_raw == '0) begin
            half = THR_MIN;
        end else if (half_raw > WIN_W'(THR_MAX)) begin
            half = THR_MAX;
        end else begin
            half = half_raw[THR_W-1:0];
        end
        fr_win_sum = (FRW_W'(half) + FRW_W'(FR_EXTRA)) << FRAC_BITS;
        fr_win     = (fr_win_sum > FRW_W'(WIN_MAX)) ? WIN_MAX : fr_win_sum[WIN_W-1:0];

        dup_bumped = (r_dup == DUP_MAX) ? r_dup : r_dup + DUP_W'(1);
        ack_gap    = ack_number - r_mark;
    end

    always_comb begin
        n_seq       = r_seq;
        n_phase     = r_phase;
        n_window    = r_window;
        n_thresh    = r_thresh;
        n_dup       = r_dup;
        n_mark      = r_mark;
        n_rtx       = r_rtx;
        n_wake      = r_wake;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        div_ctl.start   = 1'b0;
        div_ctl.divisor = r_window;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_seq)
            SQ_IDLE: begin
                if (s_accept) begin
                    n_rtx  = 1'b0;
                    n_wake = 1'b0;
                    n_seq  = SQ_DONE;
                    case (r_phase)
                        PH_OPEN, PH_DISORDER: begin
                            if (ack_is_new) begin
                                n_dup   = '0;
                                n_phase = PH_OPEN;
                                if (in_slow_start) begin
                                    n_window = win_ss;
                                end else begin
                                    div_ctl.start = 1'b1;
                                    n_seq         = SQ_DIV;
                                end
                            end else begin
                                n_dup = dup_bumped;
                                if (dup_bumped >= DUP_W'(r_dup_th)) begin
                                    n_thresh = half;
                                    n_window = fr_win;
                                    n_mark   = send_next;
                                    n_phase  = PH_RECOVERY;
                                    n_rtx    = 1'b1;
                                end
                            end
                        end
                        PH_RECOVERY: begin
                            if (ack_is_new) begin
                                // serial-number test against the recovery point
                                if (ack_gap[SEQ_W-1]) begin
                                    n_window = win_ss;
                                    n_rtx    = 1'b1;
                                end else begin
                                    n_phase = PH_DISORDER;
                                    n_dup   = '0;
                                end
                            end else begin
                                n_window = win_ss;
                                n_dup    = dup_bumped;
                                n_wake   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            SQ_DIV: begin
                if (div_sts.done) begin
                    n_window = win_ca;
                    n_seq    = SQ_DONE;
                end
            end
            SQ_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_dup, r_phase, r_thresh, r_window};
                    n_out_user  = {r_wake, r_rtx};
                    n_seq       = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_phase     <= PH_OPEN;
            r_window    <= WIN_RESET;
            r_thresh    <= THR_MAX;
            r_dup       <= '0;
            r_mark      <= '0;
            r_dup_th    <= DTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_window    <= n_window;
            r_thresh    <= n_thresh;
            r_dup       <= n_dup;
            r_mark      <= n_mark;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_dup_th <= i_cfg_data;
            end
        end
        r_rtx      <= n_rtx;
        r_wake     <= n_wake;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // an accepted beat always takes the sequencer out of idle in the following cycle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_seq != SQ_IDLE))
        else $error("accepted beat did not leave idle");

    // the divider only reports completion while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_seq == SQ_DIV))
        else $error("divider finished outside the division step");

    // the window never falls below one segment
    a_window_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window >= ONE_MSS)
        else $error("window below one segment");

    // the divider is never busy while the block offers ready
    a_div_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !div_sts.busy)
        else $error("divider busy while idle");

endmodule

`default_nettype wire
